>>> design/pal_pkg.sv
// shared types and constants for the paged array lru frame manager
package pal_pkg;

  localparam int IDX_W  = 32;
  localparam int PS_W   = 17;
  localparam int OFF_W  = 16;
  localparam int FRM_W  = 3;
  localparam int CNT_W  = 32;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // largest page size the block honors
  localparam logic [PS_W-1:0] PAGE_MAX       = PS_W'(65536);
  localparam logic [PS_W-1:0] PAGE_SIZE_RST  = PS_W'(256);

  // register indexes
  localparam logic REG_PAGE_SIZE = 1'b0;

  // depth of the queue between the divider and the frame lookup
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [IDX_W-1:0] page;
    logic [OFF_W-1:0] off;
  } pal_job_t;

endpackage

>>> design/paged_array_lru_frame_manager.sv
// top level of the paged array lru frame manager
//
// usage:
//   input channel (item_valid / item_stall) carries one element_index per beat.
//   result channel (result_valid / result_stall) returns one beat per input
//   beat, in order: hit, frame, offset, page_number, writeback, evicted_page
//   and the running hit and fault totals after that access.
//   page_size is set through the apb port at byte address 0; the user must
//   write it only while idle; the block does not enforce this.
// intake: the front part takes a new beat only once the serial divider has
//   pushed the last one (accept, quotient bits, queue push).
// path: divider, queue, then a match state and a commit state in the back part.
// reset: rst is synchronous; it empties the frames, clears recency ranks,
//   fill pointer and both totals, and sets page_size back to 256.
// stall: a stalled result holds in the output register; the back part waits,
//   the two-entry queue absorbs finished divisions, and the front part holds
//   its finished division while the queue is full, its input stalled until
//   the push (the input is stalled anyway while a division runs).
module paged_array_lru_frame_manager #(
  parameter int FRAMES = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pal_pkg::ADDR_W-1:0]   paddr,
  input  logic [pal_pkg::DATA_W-1:0]   pwdata,
  output logic [pal_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  // input channel
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [pal_pkg::IDX_W-1:0]    element_index,
  // result channel
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         hit,
  output logic [pal_pkg::FRM_W-1:0]    frame,
  output logic [pal_pkg::OFF_W-1:0]    offset,
  output logic [pal_pkg::IDX_W-1:0]    page_number,
  output logic                         writeback,
  output logic [pal_pkg::IDX_W-1:0]    evicted_page,
  output logic [pal_pkg::CNT_W-1:0]    hit_total,
  output logic [pal_pkg::CNT_W-1:0]    fault_total
);
  import pal_pkg::*;

  logic [PS_W-1:0] page_size;
  logic            reg_sel;

  logic     push;
  logic     q_full;
  logic     q_valid;
  logic     pop;
  pal_job_t push_job;
  pal_job_t head;

  // word index of the register; the low byte bits are ignored
  assign reg_sel = paddr[ADDR_W-1];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size <= PAGE_SIZE_RST;
    end else if (psel && penable && pwrite && reg_sel == REG_PAGE_SIZE) begin
      page_size <= pwdata[PS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_PAGE_SIZE) begin
      prdata = DATA_W'(page_size);
    end
  end

  // divider: page number and offset
  pal_front u_front (
    .clk           (clk),
    .rst           (rst),
    .page_size     (page_size),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .element_index (element_index),
    .push          (push),
    .job           (push_job),
    .q_full        (q_full)
  );

  // decouples the divider from the frame lookup
  pal_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  // frame lookup, replacement and result register
  pal_back #(
    .FRAMES (FRAMES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .hit          (hit),
    .frame        (frame),
    .offset       (offset),
    .page_number  (page_number),
    .writeback    (writeback),
    .evicted_page (evicted_page),
    .hit_total    (hit_total),
    .fault_total  (fault_total)
  );

endmodule

>>> design/pal_front.sv
// front part: accepts element indexes and splits them into page and offset
module pal_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [pal_pkg::PS_W-1:0]   page_size,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [pal_pkg::IDX_W-1:0]  element_index,
  output logic                       push,
  output pal_pkg::pal_job_t          job,
  input  logic                       q_full
);
  import pal_pkg::*;

  localparam int STEP_W = $clog2(IDX_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(IDX_W - 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t state;
  logic [STEP_W-1:0] step;
  logic [PS_W-1:0]   divisor;
  logic [IDX_W-1:0]  quo;
  logic [OFF_W-1:0]  rem;
  logic [PS_W-1:0]   ps_eff;
  logic [PS_W-1:0]   trial;
  logic              ge;

  // zero acts as one, anything past the top acts as the top
  always_comb begin
    if (page_size == '0) begin
      ps_eff = PS_W'(1);
    end else if (page_size > PAGE_MAX) begin
      ps_eff = PAGE_MAX;
    end else begin
      ps_eff = page_size;
    end
  end

  // restoring division, one quotient bit a cycle
  assign trial = {rem, quo[IDX_W-1]};
  assign ge    = trial >= divisor;

  assign item_stall = (state != F_IDLE);
  assign push       = (state == F_PUSH) && !q_full;
  assign job.page   = quo;
  assign job.off    = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (item_valid) begin
            state <= F_DIV;
            step  <= '0;
          end
        end
        F_DIV: begin
          step <= step + STEP_W'(1);
          if (step == LAST_STEP) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && item_valid) begin
      divisor <= ps_eff;
      quo     <= element_index;
      rem     <= '0;
    end else if (state == F_DIV) begin
      quo <= {quo[IDX_W-2:0], ge};
      rem <= ge ? OFF_W'(trial - divisor) : trial[OFF_W-1:0];
    end
  end

endmodule

>>> design/pal_fifo.sv
// short queue of split indexes between the front and back parts
module pal_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pal_pkg::pal_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output pal_pkg::pal_job_t head
);
  import pal_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_Q = $clog2(QDEPTH + 1);

  pal_job_t slot [QDEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_Q-1:0] fill;

  assign full    = (fill == CNT_Q'(QDEPTH));
  assign q_valid = (fill != '0);
  assign head    = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PTR_W'(QDEPTH - 1)) ? '0 : wp + PTR_W'(1);
      end
      if (pop) begin
        rp <= (rp == PTR_W'(QDEPTH - 1)) ? '0 : rp + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_Q'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_Q'(1);
      end
    end
  end

endmodule

>>> design/pal_back.sv
// back part: frame lookup, lru replacement, counters and result register
module pal_back #(
  parameter int FRAMES = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  pal_pkg::pal_job_t          head,
  output logic                       pop,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic                       hit,
  output logic [pal_pkg::FRM_W-1:0]  frame,
  output logic [pal_pkg::OFF_W-1:0]  offset,
  output logic [pal_pkg::IDX_W-1:0]  page_number,
  output logic                       writeback,
  output logic [pal_pkg::IDX_W-1:0]  evicted_page,
  output logic [pal_pkg::CNT_W-1:0]  hit_total,
  output logic [pal_pkg::CNT_W-1:0]  fault_total
);
  import pal_pkg::*;

  localparam int FI_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FP_W = $clog2(FRAMES + 1);
  localparam logic [FI_W-1:0] OLDEST = FI_W'(FRAMES - 1);

  typedef enum logic [2:0] {
    B_IDLE   = 3'b001,
    B_MATCH  = 3'b010,
    B_COMMIT = 3'b100
  } back_state_t;

  back_state_t state;
  pal_job_t cur;

  logic [IDX_W-1:0] tag  [FRAMES];
  logic [FI_W-1:0]  rank [FRAMES];
  logic [FP_W-1:0]  fill_ptr;
  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] fault_cnt;

  logic [FRAMES-1:0] fvalid;
  logic              full;
  logic              m_hit;
  logic [FI_W-1:0]   m_idx;
  logic [FI_W-1:0]   v_idx;
  logic [IDX_W-1:0]  v_tag;

  logic              hit_q;
  logic              full_q;
  logic [FI_W-1:0]   hit_idx_q;
  logic [FI_W-1:0]   hit_rank_q;
  logic [FI_W-1:0]   vic_idx_q;
  logic [IDX_W-1:0]  vic_tag_q;

  logic              commit;
  logic [FI_W-1:0]   f_sel;

  // frames fill in order and never empty, so occupancy follows the fill pointer
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      fvalid[i] = (FP_W'(i) < fill_ptr);
    end
  end
  assign full = (fill_ptr == FP_W'(FRAMES));

  // lowest matching frame wins; when full the oldest frame carries the top rank
  always_comb begin
    m_hit = 1'b0;
    m_idx = '0;
    v_idx = '0;
    v_tag = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (fvalid[i] && tag[i] == cur.page) begin
        m_hit = 1'b1;
        m_idx = FI_W'(i);
      end
      if (fvalid[i] && rank[i] == OLDEST) begin
        v_idx = FI_W'(i);
        v_tag = tag[i];
      end
    end
  end

  assign pop    = (state == B_IDLE) && q_valid;
  assign commit = (state == B_COMMIT) && (!result_valid || !result_stall);
  assign f_sel  = hit_q ? hit_idx_q : (full_q ? vic_idx_q : fill_ptr[FI_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE:   if (q_valid) state <= B_MATCH;
        B_MATCH:  state <= B_COMMIT;
        B_COMMIT: if (commit) state <= B_IDLE;
        default:  state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == B_MATCH) begin
      hit_q      <= m_hit;
      full_q     <= full;
      hit_idx_q  <= m_idx;
      hit_rank_q <= rank[m_idx];
      vic_idx_q  <= v_idx;
      vic_tag_q  <= v_tag;
    end
  end

  // tags are written only on a fault
  always_ff @(posedge clk) begin
    if (commit && !hit_q) begin
      tag[f_sel] <= cur.page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_ptr     <= '0;
      hit_cnt      <= '0;
      fault_cnt    <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (commit) begin
        result_valid <= 1'b1;
        if (hit_q) begin
          hit_cnt <= hit_cnt + CNT_W'(1);
        end else begin
          fault_cnt <= fault_cnt + CNT_W'(1);
          if (!full_q) begin
            fill_ptr <= fill_ptr + FP_W'(1);
          end
        end
        // selected frame becomes newest, the frames newer than it age by one
        for (int i = 0; i < FRAMES; i++) begin
          if (FI_W'(i) == f_sel) begin
            rank[i] <= '0;
          end else if (fvalid[i] && (!hit_q || rank[i] < hit_rank_q)) begin
            rank[i] <= rank[i] + FI_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit          <= hit_q;
      frame        <= FRM_W'(f_sel);
      offset       <= cur.off;
      page_number  <= cur.page;
      writeback    <= !hit_q && full_q;
      evicted_page <= (!hit_q && full_q) ? vic_tag_q : '0;
      hit_total    <= hit_q ? hit_cnt + CNT_W'(1) : hit_cnt;
      fault_total  <= hit_q ? fault_cnt : fault_cnt + CNT_W'(1);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_ptr <= FP_W'(FRAMES))
    else $error("fill pointer past frame count");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    commit && !hit_q && !full_q |=> fill_ptr == $past(fill_ptr) + FP_W'(1))
    else $error("fill pointer did not advance on fill");

  a_hit_keeps_faults: assert property (@(posedge clk) disable iff (rst)
    commit && hit_q |=> fault_cnt == $past(fault_cnt))
    else $error("fault count moved on a hit");

  a_wb_on_miss: assert property (@(posedge clk) disable iff (rst)
    result_valid && writeback |-> !hit)
    else $error("write-back reported on a hit");

endmodule
